### src/sbpd_pkg.sv
// Shared types and constants for the sliced-bit parity deframer.
`default_nettype none
package sbpd_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int SUM_WIDTH    = SAMPLE_WIDTH + 2;
  localparam int DATA_BITS    = 8;
  localparam int CNT_WIDTH    = $clog2(DATA_BITS);
  localparam logic [CNT_WIDTH-1:0] LAST_DATA = CNT_WIDTH'(DATA_BITS - 1);

  localparam int QUEUE_DEPTH  = 4;
  localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW     = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_a;
    logic signed [SAMPLE_WIDTH-1:0] sample_b;
    logic signed [SAMPLE_WIDTH-1:0] sample_c;
  } in_beat_t;

  typedef struct packed {
    logic                 byte_ready;
    logic [DATA_BITS-1:0] data_byte;
    logic                 parity_error;
  } out_beat_t;

  // Sliced symbol: has_bit is low for a zero sum.
  typedef struct packed {
    logic has_bit;
    logic bit_val;
  } slice_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DATA   = 3'b010,
    ST_PARITY = 3'b100
  } frame_state_t;

endpackage
`default_nettype wire

### src/sliced_bit_parity_deframer.sv
// Sliced-bit deframer: 3-sample slicer, symbol queue, even-parity 8-bit frame decoder.
// Path: an accepted input beat is registered in the slicer, stored in the symbol queue, then registered at the output.
// Throughput: one beat per cycle when nothing stalls, set by the slicer add and deframer update.
// A 4-entry symbol queue lets the slicer keep taking beats while the output is stalled.
// Reset (rst, synchronous, active high) empties the queue, drops all valids and
// returns the frame decoder to idle with byte and parity cleared.
`default_nettype none
module sliced_bit_parity_deframer (
  input  wire                 logic clk,
  input  wire                 logic rst,
  input  wire                 logic in_valid,
  output logic                in_stall,
  input  wire sbpd_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  wire                 logic out_stall,
  output sbpd_pkg::out_beat_t out_data
);

  // Front to queue.
  logic                push;
  sbpd_pkg::slice_t    push_entry;
  // Queue to back end.
  logic                pop;
  sbpd_pkg::slice_t    pop_entry;
  sbpd_pkg::q_status_t q_status;

  // Slicer: sum of the three samples, sign gives the bit, zero gives none.
  sbpd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  // Decouples slicer from deframer so an output stall does not block input at once.
  sbpd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .status     (q_status)
  );

  // Deframer: start bit, eight data bits LSB first, even parity; one beat out per symbol.
  sbpd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_status   (q_status),
    .pop_entry  (pop_entry),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

`ifndef ASSERT_OFF
  // A frame ends either good or bad, never both.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.byte_ready && out_data.parity_error))
    else $error("byte_ready and parity_error both set");

  // Byte lane is zero unless a good frame is reported.
  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.byte_ready) |-> (out_data.data_byte == '0))
    else $error("data_byte nonzero without byte_ready");

  // Queue status is consistent.
  a_queue_status: assert property (@(posedge clk) disable iff (rst)
    !(q_status.full && q_status.empty))
    else $error("queue full and empty together");

  // A beat is popped only while the output register can take it.
  a_pop_room: assert property (@(posedge clk) disable iff (rst)
    pop |-> (!q_status.empty && (!out_valid || !out_stall)))
    else $error("pop without room or data");
`endif

endmodule
`default_nettype wire

### src/sbpd_front.sv
// Front stage: accepts sample beats and slices their sum into a symbol.
`default_nettype none
module sbpd_front (
  input  wire                logic clk,
  input  wire                logic rst,
  input  wire                logic in_valid,
  output logic               in_stall,
  input  wire sbpd_pkg::in_beat_t  in_data,
  input  wire sbpd_pkg::q_status_t q_status,
  output logic               push,
  output sbpd_pkg::slice_t   push_entry
);

  logic                                   f_valid;
  sbpd_pkg::slice_t                       f_slice;
  sbpd_pkg::slice_t                       slice_next;
  logic signed [sbpd_pkg::SUM_WIDTH-1:0]  sum;

  always_comb begin
    sum = sbpd_pkg::SUM_WIDTH'(in_data.sample_a)
        + sbpd_pkg::SUM_WIDTH'(in_data.sample_b)
        + sbpd_pkg::SUM_WIDTH'(in_data.sample_c);
    slice_next.has_bit = (sum != '0);
    slice_next.bit_val = sum[sbpd_pkg::SUM_WIDTH-1];
  end

  assign in_stall   = f_valid && q_status.full;
  assign push       = f_valid && !q_status.full;
  assign push_entry = f_slice;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (!in_stall) begin
      f_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      f_slice <= slice_next;
    end
  end

endmodule
`default_nettype wire

### src/sbpd_queue.sv
// Short symbol queue between the slicer and the deframer.
`default_nettype none
module sbpd_queue (
  input  wire                 logic clk,
  input  wire                 logic rst,
  input  wire                 logic push,
  input  wire sbpd_pkg::slice_t     push_entry,
  input  wire                 logic pop,
  output sbpd_pkg::slice_t    pop_entry,
  output sbpd_pkg::q_status_t status
);

  sbpd_pkg::slice_t                 mem [sbpd_pkg::QUEUE_DEPTH];
  logic [sbpd_pkg::QUEUE_AW-1:0]    wr_ptr;
  logic [sbpd_pkg::QUEUE_AW-1:0]    rd_ptr;
  logic [sbpd_pkg::QUEUE_CW-1:0]    count;

  assign status.full  = (count == sbpd_pkg::QUEUE_CW'(sbpd_pkg::QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign pop_entry    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### src/sbpd_back.sv
// Back end: frame state machine, parity check and output register.
`default_nettype none
module sbpd_back (
  input  wire                 logic clk,
  input  wire                 logic rst,
  input  wire sbpd_pkg::q_status_t  q_status,
  input  wire sbpd_pkg::slice_t     pop_entry,
  output logic                pop,
  output logic                out_valid,
  input  wire                 logic out_stall,
  output sbpd_pkg::out_beat_t out_data
);

  sbpd_pkg::frame_state_t                state;
  sbpd_pkg::frame_state_t                state_next;
  logic [sbpd_pkg::CNT_WIDTH-1:0]        cnt;
  logic [sbpd_pkg::CNT_WIDTH-1:0]        cnt_next;
  logic [sbpd_pkg::DATA_BITS-1:0]        shift_byte;
  logic [sbpd_pkg::DATA_BITS-1:0]        shift_byte_next;
  logic                                  parity_acc;
  logic                                  parity_acc_next;
  sbpd_pkg::out_beat_t                   res;

  assign pop = !q_status.empty && (!out_valid || !out_stall);

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    shift_byte_next = shift_byte;
    parity_acc_next = parity_acc;
    res             = '0;
    if (pop && pop_entry.has_bit) begin
      unique case (state)
        sbpd_pkg::ST_IDLE: begin
          if (!pop_entry.bit_val) begin
            state_next = sbpd_pkg::ST_DATA;
            cnt_next   = '0;
          end
        end
        sbpd_pkg::ST_DATA: begin
          shift_byte_next = {pop_entry.bit_val, shift_byte[sbpd_pkg::DATA_BITS-1:1]};
          parity_acc_next = parity_acc ^ pop_entry.bit_val;
          cnt_next        = cnt + 1'b1;
          if (cnt == sbpd_pkg::LAST_DATA) begin
            state_next = sbpd_pkg::ST_PARITY;
          end
        end
        sbpd_pkg::ST_PARITY: begin
          if (pop_entry.bit_val == parity_acc) begin
            res.byte_ready = 1'b1;
            res.data_byte  = shift_byte;
          end else begin
            res.parity_error = 1'b1;
          end
          state_next      = sbpd_pkg::ST_IDLE;
          cnt_next        = '0;
          shift_byte_next = '0;
          parity_acc_next = 1'b0;
        end
        default: begin
          state_next      = sbpd_pkg::ST_IDLE;
          cnt_next        = '0;
          shift_byte_next = '0;
          parity_acc_next = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sbpd_pkg::ST_IDLE;
      cnt        <= '0;
      shift_byte <= '0;
      parity_acc <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      shift_byte <= shift_byte_next;
      parity_acc <= parity_acc_next;
      if (pop) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data <= res;
    end
  end

endmodule
`default_nettype wire

### test/tb_top.sv
// Testbench for the sliced-bit parity deframer: random and directed sample beats, self-checked.
`timescale 1ns / 100ps

module tb_top;
  import sbpd_pkg::*;

  // Symbol that a sample triple should slice to: a 0 or 1 bit, or no bit (zero sum).
  typedef enum {SYM_ZERO, SYM_ONE, SYM_NONE} symbol_t;

  localparam int RANDOM_BEATS = 1800;
  localparam int SMIN = -(2 ** (SAMPLE_WIDTH - 1));
  localparam int SMAX = 2 ** (SAMPLE_WIDTH - 1) - 1;

  // Keeps its own copy of the frame decoder state and the output beats still owed.
  class deframer_scoreboard;
    frame_state_t         phase;
    int unsigned          bits_seen;
    logic [DATA_BITS-1:0] shift_byte;
    logic                 parity_acc;
    out_beat_t            awaited_beats[$];
    int unsigned          errors;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      phase      = ST_IDLE;
      bits_seen  = 0;
      shift_byte = '0;
      parity_acc = 1'b0;
    endfunction

    // Slice the three samples into a bit and advance the frame decoder.
    function out_beat_t slice_and_deframe(in_beat_t s);
      logic signed [SUM_WIDTH-1:0] total;
      logic                        b;
      out_beat_t                   res;
      res   = '0;
      total = $signed(s.sample_a) + $signed(s.sample_b) + $signed(s.sample_c);
      if (total == 0) return res;
      b = total[SUM_WIDTH-1];
      case (phase)
        ST_IDLE: begin
          if (!b) begin
            phase     = ST_DATA;
            bits_seen = 0;
          end
        end
        ST_DATA: begin
          shift_byte = {b, shift_byte[DATA_BITS-1:1]};
          parity_acc = parity_acc ^ b;
          bits_seen++;
          if (bits_seen == DATA_BITS) phase = ST_PARITY;
        end
        ST_PARITY: begin
          if (b == parity_acc) begin
            res.byte_ready = 1'b1;
            res.data_byte  = shift_byte;
          end else begin
            res.parity_error = 1'b1;
          end
          restart();
        end
        default: restart();
      endcase
      return res;
    endfunction

    function void note_samples(in_beat_t s);
      awaited_beats.push_back(slice_and_deframe(s));
    endfunction

    function int pending();
      return awaited_beats.size();
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_beat(out_beat_t got);
      out_beat_t want;
      if (awaited_beats.size() == 0) begin
        report($sformatf("unexpected output beat %p", got));
        return;
      end
      want = awaited_beats.pop_front();
      if (got.byte_ready !== want.byte_ready)
        report($sformatf("byte_ready %b, want %b", got.byte_ready, want.byte_ready));
      if (got.data_byte !== want.data_byte)
        report($sformatf("data_byte %h, want %h", got.data_byte, want.data_byte));
      if (got.parity_error !== want.parity_error)
        report($sformatf("parity_error %b, want %b", got.parity_error, want.parity_error));
    endtask
  endclass

  // All block inputs start at known values; reset is held from time zero.
  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  in_beat_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_beat_t out_data;

  deframer_scoreboard deframe_sb = new();

  // calm: neither side idles. hold_request: asks the receiver for one long hold-off.
  bit          calm         = 1'b0;
  bit          hold_request = 1'b0;
  int unsigned beats_sent   = 0;

  always #5 clk = ~clk;

  sliced_bit_parity_deframer uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Idle length: mostly none, often short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Full-range values, small ones near zero (close sums), or corner values.
  function automatic int pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom_range(0, 2 * SMAX + 1) + SMIN;
    if (r < 8) return $urandom_range(0, 128) - 64;
    case ($urandom_range(0, 4))
      0: return SMIN;
      1: return SMAX;
      2: return -1;
      3: return 1;
      default: return 0;
    endcase
  endfunction

  // Draw triples until one slices to the wanted symbol.
  function automatic in_beat_t make_samples(symbol_t sym);
    in_beat_t x;
    int       a, b, c, total;
    do begin
      a = pick_sample();
      b = pick_sample();
      c = (sym == SYM_NONE) ? -(a + b) : pick_sample();
      total = a + b + c;
    end while ((sym == SYM_NONE && (c < SMIN || c > SMAX)) ||
               (sym == SYM_ONE && total >= 0) ||
               (sym == SYM_ZERO && total <= 0));
    x.sample_a = SAMPLE_WIDTH'(a);
    x.sample_b = SAMPLE_WIDTH'(b);
    x.sample_c = SAMPLE_WIDTH'(c);
    return x;
  endfunction

  // Offer one beat, hold it until taken, then maybe idle.
  // valid only drops when a gap follows, so it never toggles within a step.
  task send_beat(input in_beat_t x);
    int gap;
    in_valid <= 1'b1;
    in_data  <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    deframe_sb.note_samples(x);
    beats_sent++;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task send_raw(input int a, input int b, input int c);
    in_beat_t x;
    x.sample_a = SAMPLE_WIDTH'(a);
    x.sample_b = SAMPLE_WIDTH'(b);
    x.sample_c = SAMPLE_WIDTH'(c);
    send_beat(x);
  endtask

  // A bit inside a frame, sometimes preceded by a zero-sum beat that carries no bit.
  task send_bit(input logic b);
    if ($urandom_range(0, 99) < 8) send_beat(make_samples(SYM_NONE));
    send_beat(make_samples(b ? SYM_ONE : SYM_ZERO));
  endtask

  // Idle ones, start bit, 8 data bits LSB first, parity bit.
  task send_frame(input bit parity_ok);
    logic [DATA_BITS-1:0] data;
    int                   idles;
    data  = DATA_BITS'($urandom);
    idles = $urandom_range(0, 3);
    repeat (idles) send_bit(1'b1);
    send_bit(1'b0);
    for (int i = 0; i < DATA_BITS; i++) send_bit(data[i]);
    send_bit(parity_ok ? ^data : ~^data);
  endtask

  // Receiver: checks taken beats and drives out_stall, one update per edge.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) deframe_sb.check_beat(out_data);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = 120;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (rst || calm || $urandom_range(0, 99) < 85) begin
        out_stall <= 1'b0;
      end else begin
        stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        out_stall <= 1'b1;
        stall_left--;
      end
    end
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int unsigned rand_base;
    int          r;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: zero sums, idle one, corner samples, good frame, bad parity.
    send_raw(0, 0, 0);                  // no bit while idle
    send_raw(SMIN, SMIN, SMIN);         // most negative sum: 1, stays idle
    send_raw(SMAX, SMIN, 1);            // cancels to zero
    send_raw(SMAX, SMAX, SMAX);         // most positive sum: start bit
    // 0xA5, LSB first: 1 0 1 0 0 1 0 1
    send_raw(-1, 0, 0);
    send_raw(1, 0, 0);
    send_raw(SMIN, SMAX, 0);            // sum -1
    send_raw(-1, 1, 0);                 // zero sum mid-frame, state holds
    send_raw(SMAX, SMAX, SMIN);
    send_raw(0, 0, 1);
    send_raw(SMIN, 0, 0);
    send_raw(0, SMAX, 0);
    send_raw(0, 0, SMIN);
    send_raw(0, 0, 5);                  // even parity of 0xA5 is 0: byte out
    // 0xFF with the wrong parity bit
    send_raw(0, 0, SMAX);
    send_raw(SMIN, SMIN, SMAX);
    send_raw(SMIN, 0, SMAX);
    send_raw(-1, -1, -1);
    send_raw(SMIN, SMIN, SMIN);
    send_raw(0, -2, 1);
    send_raw(SMIN, SMAX, SMIN);
    send_raw(-100, 50, 49);
    send_raw(-3, 0, 0);
    send_raw(-5, 0, 0);                 // parity should be 0: error flag

    // Back-pressure: receiver holds off long while beats keep coming.
    calm         = 1'b1;
    hold_request = 1'b1;
    repeat (4) send_frame(1'b1);
    calm = 1'b0;

    // Random: mostly well-formed frames, some bad parity, some noise.
    rand_base = beats_sent;
    while (beats_sent - rand_base < RANDOM_BEATS) begin
      if ($urandom_range(0, 7) == 0) calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 70) begin
        send_frame(1'b1);
      end else if (r < 82) begin
        send_frame(1'b0);
      end else begin
        repeat ($urandom_range(1, 10))
          send_beat(make_samples(symbol_t'($urandom_range(0, 2))));
      end
    end
    in_valid <= 1'b0;

    while (deframe_sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (deframe_sb.errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
